>>> hdl/bqf_pkg.sv
// Package for the multichannel biquad filter: widths, fixed-point constants,
// register index codes, sequencer states and the serial multiplier control word.
// No dependencies.
package bqf_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int CH_W         = 4;
  localparam int COEF_W       = 32;
  localparam int STATE_W      = 40;
  localparam int FRAC_SHIFT   = 20;
  localparam int GUARD_SHIFT  = 8;
  localparam int PROD_W       = COEF_W + SAMPLE_W + 1;
  localparam int RND_W        = PROD_W - FRAC_SHIFT;
  localparam int ACC_W        = STATE_W + 1;
  localparam int YPRE_W       = ACC_W - GUARD_SHIFT;
  localparam int CNT_W        = $clog2(SAMPLE_W);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = COEF_W;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam logic signed [COEF_W-1:0] COEF_FF0_RST = COEF_W'(32'sh1000_0000);
  localparam logic signed [COEF_W-1:0] COEF_ZERO    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_FF0    = 3'd1,
    CFG_FF1    = 3'd2,
    CFG_FF2    = 3'd3,
    CFG_FB1    = 3'd4,
    CFG_FB2    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_X,
    S_RND0,
    S_ACC,
    S_SATY,
    S_MUL_Y,
    S_DIFF,
    S_RND1,
    S_UPD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic mbit;
    logic msb;
  } mul_ctrl_t;

endpackage

>>> hdl/bqf_if.sv
// Stream interfaces for the biquad filter: input word and output word channels.
// Depends on bqf_pkg.
interface bqf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  sample_in;
  logic        [bqf_pkg::CH_W-1:0]      channel;
  logic                                 end_of_block;

  modport source (output valid, sample_in, channel, end_of_block, input ready);
  modport sink   (input valid, sample_in, channel, end_of_block, output ready);
endinterface

interface bqf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bqf_pkg::SAMPLE_W-1:0]  sample_out;
  logic        [bqf_pkg::CH_W-1:0]      channel_out;
  logic                                 last_out;

  modport source (output valid, sample_out, channel_out, last_out, input ready);
  modport sink   (input valid, sample_out, channel_out, last_out, output ready);
endinterface

>>> hdl/bqf_serial_mul.sv
// Bit-serial signed multiplier: coefficient times a sample fed LSB first,
// one bit per step, sign bit weighted negative. Depends on bqf_pkg.
module bqf_serial_mul (
  input  logic                                clk_i,
  input  bqf_pkg::mul_ctrl_t                  ctrl_i,
  input  logic signed [bqf_pkg::COEF_W-1:0]   coef_i,
  output logic signed [bqf_pkg::PROD_W-1:0]   prod_o
);

  localparam int HI_W = bqf_pkg::COEF_W + 1;

  logic signed [HI_W-1:0]               hi_q, hi_d;
  logic        [bqf_pkg::SAMPLE_W-1:0]  lo_q, lo_d;
  logic signed [HI_W-1:0]               coef_ext;
  logic signed [HI_W-1:0]               addend;
  logic signed [HI_W:0]                 sum;

  assign coef_ext = HI_W'(coef_i);

  always_comb begin
    addend = '0;
    if (ctrl_i.mbit) begin
      addend = ctrl_i.msb ? -coef_ext : coef_ext;
    end
    sum  = (HI_W+1)'(hi_q) + (HI_W+1)'(addend);
    hi_d = sum[HI_W:1];
    lo_d = {sum[0], lo_q[bqf_pkg::SAMPLE_W-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (ctrl_i.step) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o = {hi_q, lo_q};

endmodule

>>> hdl/bqf_delay_store.sv
// Per-channel delay state (two 40-bit words per channel), cleared by reset,
// one write port, registered read. Depends on bqf_pkg.
module bqf_delay_store #(
  parameter int MAX_CHANNELS = bqf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bqf_pkg::CH_W-1:0]            addr_i,
  input  logic                                we_i,
  input  logic signed [bqf_pkg::STATE_W-1:0]  wr_one_i,
  input  logic signed [bqf_pkg::STATE_W-1:0]  wr_two_i,
  output logic signed [bqf_pkg::STATE_W-1:0]  rd_one_o,
  output logic signed [bqf_pkg::STATE_W-1:0]  rd_two_o
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [bqf_pkg::STATE_W-1:0] one_q [MAX_CHANNELS];
  logic signed [bqf_pkg::STATE_W-1:0] two_q [MAX_CHANNELS];
  logic [AW-1:0] idx;

  assign idx = addr_i[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        one_q[i] <= '0;
        two_q[i] <= '0;
      end
    end else if (we_i) begin
      one_q[idx] <= wr_one_i;
      two_q[idx] <= wr_two_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_one_o <= one_q[idx];
    rd_two_o <= two_q[idx];
  end

endmodule

>>> hdl/biquad_filter_multichannel.sv
// Multichannel transposed direct form II biquad, bit-serial arithmetic.
// Depends on bqf_pkg, bqf_if, bqf_serial_mul, bqf_delay_store.
//
//   channel | dir | handshake   | word
//   in_i    | in  | valid/ready | sample_in[23:0], channel[3:0], end_of_block
//   out_o   | out | valid/ready | sample_out[23:0], channel_out[3:0], last_out
//   cfg     | in  | cfg_we_i    | cfg_idx_i[2:0], cfg_wdata_i[31:0]
//
// A filtered word goes from accept to the output register through two passes
// of the bit-serial multipliers (input sample, then output sample) plus
// rounding, accumulate and state update steps.
// A passed-through word skips the multipliers and goes straight to S_OUT.
// One word is in flight; the next is accepted while the last result waits.
// Reset clears the delay state of every channel and loads register defaults.
module biquad_filter_multichannel #(
  parameter int MAX_CHANNELS = bqf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  bqf_in_if.sink                               in_i,
  bqf_out_if.source                            out_o,
  input  logic                                 cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bqf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int SW = bqf_pkg::SAMPLE_W;
  localparam int PW = bqf_pkg::PROD_W;
  localparam int RW = bqf_pkg::RND_W;
  localparam int AW = bqf_pkg::ACC_W;
  localparam int YW = bqf_pkg::YPRE_W;
  localparam int DW = bqf_pkg::STATE_W;
  localparam int CW = bqf_pkg::CH_W;
  localparam int NW = bqf_pkg::CNT_W;

  localparam logic signed [PW-1:0] RND_FRAC  = PW'(1) << (bqf_pkg::FRAC_SHIFT - 1);
  localparam logic signed [AW-1:0] RND_GUARD = AW'(1) << (bqf_pkg::GUARD_SHIFT - 1);

  // configuration
  logic                                  enable_q;
  logic signed [bqf_pkg::COEF_W-1:0]     ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      ff0_q    <= bqf_pkg::COEF_FF0_RST;
      ff1_q    <= bqf_pkg::COEF_ZERO;
      ff2_q    <= bqf_pkg::COEF_ZERO;
      fb1_q    <= bqf_pkg::COEF_ZERO;
      fb2_q    <= bqf_pkg::COEF_ZERO;
    end else if (cfg_we_i) begin
      unique case (bqf_pkg::cfg_idx_e'(cfg_idx_i))
        bqf_pkg::CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        bqf_pkg::CFG_FF0:    ff0_q    <= cfg_wdata_i;
        bqf_pkg::CFG_FF1:    ff1_q    <= cfg_wdata_i;
        bqf_pkg::CFG_FF2:    ff2_q    <= cfg_wdata_i;
        bqf_pkg::CFG_FB1:    fb1_q    <= cfg_wdata_i;
        bqf_pkg::CFG_FB2:    fb2_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  bqf_pkg::state_e state_q, state_d;
  logic [NW-1:0]   cnt_q;
  logic            last_bit;
  logic            accept;
  logic            bypass_in;
  logic            bypass_q;
  logic            out_valid_q;
  logic            out_free;
  logic            out_load;
  logic            store_we;
  bqf_pkg::mul_ctrl_t ctrl_x, ctrl_y;

  logic signed [SW-1:0] x_q;
  logic        [SW-1:0] x_sr_q, y_sr_q;
  logic        [CW-1:0] ch_q;
  logic                 eob_q;

  assign last_bit  = (cnt_q == NW'(SW - 1));
  assign out_free  = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign bypass_in = !enable_q || ({1'b0, in_i.channel} >= (CW+1)'(MAX_CHANNELS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bqf_pkg::S_IDLE:  if (in_i.valid) begin
                          state_d = bypass_in ? bqf_pkg::S_OUT : bqf_pkg::S_MUL_X;
                        end
      bqf_pkg::S_MUL_X: if (last_bit) state_d = bqf_pkg::S_RND0;
      bqf_pkg::S_RND0:  state_d = bqf_pkg::S_ACC;
      bqf_pkg::S_ACC:   state_d = bqf_pkg::S_SATY;
      bqf_pkg::S_SATY:  state_d = bqf_pkg::S_MUL_Y;
      bqf_pkg::S_MUL_Y: if (last_bit) state_d = bqf_pkg::S_DIFF;
      bqf_pkg::S_DIFF:  state_d = bqf_pkg::S_RND1;
      bqf_pkg::S_RND1:  state_d = bqf_pkg::S_UPD;
      bqf_pkg::S_UPD:   state_d = bqf_pkg::S_OUT;
      bqf_pkg::S_OUT:   if (out_free) state_d = bqf_pkg::S_IDLE;
      default:          state_d = bqf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready   = (state_q == bqf_pkg::S_IDLE);
    ctrl_x.start = accept;
    ctrl_x.step  = (state_q == bqf_pkg::S_MUL_X);
    ctrl_x.mbit  = x_sr_q[0];
    ctrl_x.msb   = last_bit;
    ctrl_y.start = (state_q == bqf_pkg::S_SATY);
    ctrl_y.step  = (state_q == bqf_pkg::S_MUL_Y);
    ctrl_y.mbit  = y_sr_q[0];
    ctrl_y.msb   = last_bit;
    store_we     = (state_q == bqf_pkg::S_UPD);
    out_load     = (state_q == bqf_pkg::S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqf_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl_x.step || ctrl_y.step) begin
        cnt_q <= last_bit ? '0 : cnt_q + NW'(1);
      end
    end
  end

  // multipliers
  logic signed [PW-1:0] p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;

  bqf_serial_mul u_mul_ff0 (.clk_i, .ctrl_i(ctrl_x), .coef_i(ff0_q), .prod_o(p_ff0));
  bqf_serial_mul u_mul_ff1 (.clk_i, .ctrl_i(ctrl_x), .coef_i(ff1_q), .prod_o(p_ff1));
  bqf_serial_mul u_mul_ff2 (.clk_i, .ctrl_i(ctrl_x), .coef_i(ff2_q), .prod_o(p_ff2));
  bqf_serial_mul u_mul_fb1 (.clk_i, .ctrl_i(ctrl_y), .coef_i(fb1_q), .prod_o(p_fb1));
  bqf_serial_mul u_mul_fb2 (.clk_i, .ctrl_i(ctrl_y), .coef_i(fb2_q), .prod_o(p_fb2));

  // delay state
  logic signed [DW-1:0] rd_one, rd_two, wr_one, wr_two;

  bqf_delay_store #(.MAX_CHANNELS(MAX_CHANNELS)) u_store (
    .clk_i,
    .rst_ni,
    .addr_i   (ch_q),
    .we_i     (store_we),
    .wr_one_i (wr_one),
    .wr_two_i (wr_two),
    .rd_one_o (rd_one),
    .rd_two_o (rd_two)
  );

  // datapath
  logic signed [PW-1:0] p0_sum, s1_sum, s2_sum;
  logic signed [RW-1:0] p0r_q, r1_q, r2_q;
  logic signed [AW-1:0] acc_q, acc_rnd, d1_sum;
  logic signed [YW-1:0] y_pre;
  logic signed [SW-1:0] y_sat, y_q;
  logic signed [PW-1:0] s1_q, s2_q;

  assign p0_sum  = p_ff0 + RND_FRAC;
  assign s1_sum  = s1_q + RND_FRAC;
  assign s2_sum  = s2_q + RND_FRAC;
  assign acc_rnd = acc_q + RND_GUARD;
  assign y_pre   = acc_rnd[AW-1:bqf_pkg::GUARD_SHIFT];
  assign d1_sum  = AW'(r1_q) + AW'(rd_two);

  always_comb begin
    if (y_pre[YW-1:SW-1] == '0 || y_pre[YW-1:SW-1] == '1) begin
      y_sat = y_pre[SW-1:0];
    end else begin
      y_sat = y_pre[YW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    if (d1_sum[AW-1] == d1_sum[AW-2]) begin
      wr_one = d1_sum[DW-1:0];
    end else begin
      wr_one = d1_sum[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    wr_two = DW'(r2_q);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q      <= in_i.sample_in;
      x_sr_q   <= in_i.sample_in;
      ch_q     <= in_i.channel;
      eob_q    <= in_i.end_of_block;
      bypass_q <= bypass_in;
    end else if (ctrl_x.step) begin
      x_sr_q <= {1'b0, x_sr_q[SW-1:1]};
    end
    unique case (state_q)
      bqf_pkg::S_RND0:  p0r_q <= p0_sum[PW-1:bqf_pkg::FRAC_SHIFT];
      bqf_pkg::S_ACC:   acc_q <= AW'(p0r_q) + AW'(rd_one);
      bqf_pkg::S_SATY: begin
        y_q    <= y_sat;
        y_sr_q <= y_sat;
      end
      bqf_pkg::S_MUL_Y: y_sr_q <= {1'b0, y_sr_q[SW-1:1]};
      bqf_pkg::S_DIFF: begin
        s1_q <= p_ff1 - p_fb1;
        s2_q <= p_ff2 - p_fb2;
      end
      bqf_pkg::S_RND1: begin
        r1_q <= s1_sum[PW-1:bqf_pkg::FRAC_SHIFT];
        r2_q <= s2_sum[PW-1:bqf_pkg::FRAC_SHIFT];
      end
      default: ;
    endcase
  end

  // output register
  logic signed [SW-1:0] out_sample_q;
  logic        [CW-1:0] out_ch_q;
  logic                 out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= bypass_q ? x_q : y_q;
      out_ch_q     <= ch_q;
      out_last_q   <= eob_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = out_sample_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.last_out    = out_last_q;

endmodule

>>> dv/bqf_checker.sv
// Scoreboard for biquad_filter_multichannel: watches the input, output and register
// write ports, predicts every output word and compares it field by field.
// Depends on bqf_pkg and bqf_if.
module bqf_checker import bqf_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bqf_in_if                     in_mon_i,
  bqf_out_if                    out_mon_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) << (SAMPLE_W - 1));
  localparam longint STATE_HI  = (longint'(1) << (STATE_W - 1)) - 1;
  localparam longint STATE_LO  = -(longint'(1) << (STATE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            channel;
    logic                       last;
  } out_word_t;

  logic      filter_on;
  longint    ff0, ff1, ff2, fb1, fb2;
  longint    delay_one [MAX_CHANNELS];
  longint    delay_two [MAX_CHANNELS];
  out_word_t expected_words [$];
  int        mismatches = 0;

  assign errors_o = mismatches;

  function automatic longint round_half_up(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one transposed DF2 step; the saturated output feeds back
  function automatic out_word_t filter_word(input logic signed [SAMPLE_W-1:0] x_in,
                                            input logic [CH_W-1:0] ch, input logic last);
    longint    x, y, acc;
    out_word_t w;
    x = longint'(x_in);
    y = x;
    if (filter_on && ch < MAX_CHANNELS) begin
      acc = round_half_up(ff0 * x, FRAC_SHIFT) + delay_one[ch];
      y   = clip(round_half_up(acc, GUARD_SHIFT), SAMPLE_LO, SAMPLE_HI);
      delay_one[ch] = clip(round_half_up(ff1 * x - fb1 * y, FRAC_SHIFT) + delay_two[ch],
                           STATE_LO, STATE_HI);
      delay_two[ch] = clip(round_half_up(ff2 * x - fb2 * y, FRAC_SHIFT), STATE_LO, STATE_HI);
    end
    w.sample  = y[SAMPLE_W-1:0];
    w.channel = ch;
    w.last    = last;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t got, want;
    if (!rst_ni) begin
      filter_on = 1'b1;
      ff0 = longint'(COEF_FF0_RST);
      ff1 = 0;
      ff2 = 0;
      fb1 = 0;
      fb2 = 0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        delay_one[c] = 0;
        delay_two[c] = 0;
      end
      expected_words.delete();
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready)
        expected_words.push_back(filter_word(in_mon_i.sample_in, in_mon_i.channel,
                                             in_mon_i.end_of_block));
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.sample  = out_mon_i.sample_out;
        got.channel = out_mon_i.channel_out;
        got.last    = out_mon_i.last_out;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected output word ch %0d sample %0d",
                                    got.channel, $signed(got.sample)));
        end else begin
          want = expected_words.pop_front();
          if (got.sample !== want.sample)
            report_mismatch($sformatf("ch %0d sample_out %0d, expected %0d", want.channel,
                                      $signed(got.sample), $signed(want.sample)));
          if (got.channel !== want.channel)
            report_mismatch($sformatf("channel_out %0d, expected %0d",
                                      got.channel, want.channel));
          if (got.last !== want.last)
            report_mismatch($sformatf("ch %0d last_out %0b, expected %0b",
                                      want.channel, got.last, want.last));
          checked_o <= checked_o + 1;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE: filter_on = cfg_wdata_i[0];
          CFG_FF0:    ff0 = longint'($signed(cfg_wdata_i));
          CFG_FF1:    ff1 = longint'($signed(cfg_wdata_i));
          CFG_FF2:    ff2 = longint'($signed(cfg_wdata_i));
          CFG_FB1:    fb1 = longint'($signed(cfg_wdata_i));
          CFG_FB2:    fb2 = longint'($signed(cfg_wdata_i));
          default: ;
        endcase
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

>>> dv/tb.sv
// Testbench top for biquad_filter_multichannel: clock, reset, register sets, input
// words with random gaps and output back-pressure; bqf_checker judges every result.
// Depends on bqf_pkg, bqf_if, the block and dv/bqf_checker.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bqf_pkg::*;

  localparam int MAX_CH           = MAX_CHANNELS_DEF;
  localparam int SEGMENTS         = 6;
  localparam int SEG_WORDS        = 142;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_PAD        = 4;
  localparam int END_PAD          = 64;
  localparam int LIMIT_NS         = 2_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP    = 24'h7F_FFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_BOTTOM = 24'h80_0000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG1   = 24'hFF_FFFF;
  localparam logic [COEF_W-1:0]   COEF_TOP      = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0]   COEF_BOTTOM   = 32'h8000_0000;
  localparam logic [COEF_W-1:0]   COEF_ONE      = 32'h1000_0000;

  typedef struct packed {
    logic              en;
    logic [COEF_W-1:0] ff0, ff1, ff2, fb1, fb2;
  } coef_set_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors, pending, checked;
  int                    words_sent = 0;
  int                    reg_sets = 0;
  int                    src_calm = 0;
  int                    sink_calm = 0;
  int                    next_ch = 0;
  bit                    quiet_tail = 1'b0;
  bit                    sink_hold_req = 1'b0;

  bqf_in_if  in_if ();
  bqf_out_if out_if ();

  biquad_filter_multichannel #(.MAX_CHANNELS(MAX_CH)) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  bqf_checker #(.MAX_CHANNELS(MAX_CH)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon_i    (in_if),
    .out_mon_i   (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #LIMIT_NS;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [COEF_W-1:0] coef_near_zero(input int span);
    return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [COEF_W-1:0] coef_extreme();
    case ($urandom_range(0, 3))
      0: return COEF_TOP;
      1: return COEF_BOTTOM;
      2: return COEF_ONE;
      default: return '0;
    endcase
  endfunction

  function automatic coef_set_t pick_coefs(input int seg);
    coef_set_t cs;
    cs.en = 1'b1;
    case (seg)
      1: begin
        cs.ff0 = $urandom;
        cs.ff1 = $urandom;
        cs.ff2 = $urandom;
        cs.fb1 = $urandom;
        cs.fb2 = $urandom;
      end
      2: begin
        cs.ff0 = coef_extreme();
        cs.ff1 = coef_extreme();
        cs.ff2 = coef_extreme();
        cs.fb1 = coef_extreme();
        cs.fb2 = coef_extreme();
      end
      default: begin
        // mild, mostly stable filters
        cs.ff0 = coef_near_zero(1 << 28);
        cs.ff1 = coef_near_zero(1 << 28);
        cs.ff2 = coef_near_zero(1 << 27);
        cs.fb1 = coef_near_zero(1 << 28);
        cs.fb2 = coef_near_zero(241591910);
      end
    endcase
    if (seg == 4) cs.en = 1'b0;
    return cs;
  endfunction

  task automatic load_regs(input coef_set_t cs);
    logic [CFG_IDX_W-1:0]  idx_list [7];
    logic [CFG_DATA_W-1:0] data_list [7];
    idx_list  = '{CFG_ENABLE, CFG_FF0, CFG_FF1, CFG_FF2, CFG_FB1, CFG_FB2, CFG_SPARE_A};
    data_list = '{{31'($urandom), cs.en}, cs.ff0, cs.ff1, cs.ff2, cs.fb1, cs.fb2, $urandom};
    if ($urandom_range(0, 1)) idx_list[6] = CFG_SPARE_B;
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_list[i];
      cfg_wdata <= data_list[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_sets++;
  endtask

  task automatic sender_gap();
    if (quiet_tail) return;
    if (src_calm > 0) begin
      src_calm--;
      return;
    end
    case ($urandom_range(0, 15))
      0: src_calm = $urandom_range(10, 60);
      1, 2, 3, 4: begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic [CH_W-1:0] ch,
                           input logic eob);
    in_if.valid        <= 1'b1;
    in_if.sample_in    <= s;
    in_if.channel      <= ch;
    in_if.end_of_block <= eob;
    do @(posedge clk); while (!in_if.ready);
    words_sent++;
    sender_gap();
  endtask

  task automatic send_random_word();
    logic [SAMPLE_W-1:0] s;
    logic [CH_W-1:0]     ch;
    case ($urandom_range(0, 9))
      0: s = $urandom_range(0, 1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
      1: s = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      default: s = SAMPLE_W'($urandom);
    endcase
    // mostly interleaved frames, sometimes a stray or unfiltered channel
    if ($urandom_range(0, 7) == 0) begin
      ch = CH_W'($urandom_range(0, 15));
    end else begin
      ch = CH_W'(next_ch);
      next_ch = (next_ch + 1) % MAX_CH;
    end
    send_word(s, ch, ($urandom_range(0, 7) == 0));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  initial begin : sink_side
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (quiet_tail || sink_calm > 0) begin
        if (sink_calm > 0) sink_calm--;
        out_if.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 15))
          0: begin
            sink_calm = $urandom_range(20, 120);
            out_if.ready <= 1'b1;
          end
          1, 2, 3: begin
            out_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
            out_if.ready <= 1'b1;
          end
          default: out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    coef_set_t cs;
    in_if.valid        <= 1'b0;
    in_if.sample_in    <= '0;
    in_if.channel      <= '0;
    in_if.end_of_block <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_ENABLE;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: unity gain, pass-through above the channel limit
    send_word(SAMPLE_TOP, 4'd0, 1'b1);
    send_word(SAMPLE_BOTTOM, 4'd7, 1'b0);
    send_word('0, 4'd15, 1'b1);
    send_word(SAMPLE_NEG1, 4'd8, 1'b0);

    // extreme coefficients, output saturation
    drain();
    cs = '{en: 1'b1, ff0: COEF_TOP, ff1: COEF_TOP, ff2: COEF_BOTTOM, fb1: COEF_BOTTOM,
           fb2: COEF_TOP};
    load_regs(cs);
    send_word(SAMPLE_TOP, 4'd0, 1'b0);
    send_word(SAMPLE_BOTTOM, 4'd0, 1'b1);
    send_word(SAMPLE_TOP, 4'd1, 1'b0);
    send_word(24'h00_0001, 4'd0, 1'b0);
    send_word(SAMPLE_BOTTOM, 4'd7, 1'b1);

    // disabled: pass-through, delay state kept
    drain();
    cs = '{en: 1'b0, ff0: COEF_BOTTOM, ff1: $urandom, ff2: $urandom, fb1: $urandom,
           fb2: $urandom};
    load_regs(cs);
    send_word(SAMPLE_TOP, 4'd0, 1'b0);
    send_word(24'h55_5555, 4'd3, 1'b1);
    send_word(SAMPLE_BOTTOM, 4'd9, 1'b0);

    // low-pass step response on a channel with leftover state
    drain();
    cs = '{en: 1'b1, ff0: 32'h0100_0000, ff1: 32'h0200_0000, ff2: 32'h0100_0000,
           fb1: 32'hE666_6666, fb2: 32'h0B33_3333};
    load_regs(cs);
    repeat (4) send_word(SAMPLE_TOP, 4'd0, 1'b0);
    send_word(SAMPLE_TOP, 4'd8, 1'b1);
    send_word(24'h2A_AAAA, 4'd15, 1'b0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      load_regs(pick_coefs(seg));
      if (seg == SEGMENTS - 1) quiet_tail = 1'b1;
      for (int n = 0; n < SEG_WORDS; n++) begin
        if (seg == 1 && n == 20) sink_hold_req = 1'b1;
        if (seg == 3 && n == SEG_WORDS / 2) drain();
        send_random_word();
      end
    end

    drain();
    repeat (END_PAD) @(posedge clk);
    $display("summary: %0d input words over %0d register sets, %0d output words compared",
             words_sent, reg_sets, checked);
    $display("summary: saturating, disabled, mild and random filters; long output stall");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
